// ===== rtl/cgr_pkg.sv =====
// Shared types and constants for the colour gradient ramp.
// No dependencies; imported by every module of the block.
`default_nettype none
package cgr_pkg;
  localparam int MaxPointsDef = 16;
  localparam int PosFracDef = 16;
  localparam int ColourW = 24;
  localparam int StatusW = 2;
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StUpdated = 2'd1;
  localparam logic [1:0] StRange = 2'd2;
  localparam logic [1:0] StFull = 2'd3;
  localparam logic ActAdd = 1'b0;
  localparam logic ActLookup = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/colour_gradient_ramp.sv =====
// Top level of the colour gradient ramp: control, cell chain and dividers.
// Depends on cgr_pkg, cgr_cell and cgr_div.
//
// Usage: beats enter on the in_ stream and each gives exactly one beat on the
// out_ stream. One item is worked on at a time. An add beat walks the cell
// chain one cell per cycle, then inserts by shifting the upper cells up
// together in the S_ADD state. A lookup walks the chain the same way, then
// runs three channel divisions in parallel, one quotient bit per cycle over
// the numerator width.
// The result sits in an output register; the next input beat is taken once
// it has been handed over, so a stalled receiver holds off the input.
// Reset empties the table and sets the end colours to black and white.
// Configuration writes are made only while idle: the user is bound to this, the block itself does not enforce it.
`default_nettype none
module colour_gradient_ramp #(
  parameter int MAX_POINTS = cgr_pkg::MaxPointsDef,
  parameter int POSITION_FRACTION_BITS = cgr_pkg::PosFracDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // action, position[17], red, green, blue, zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // colour, status, zero pad
);
  import cgr_pkg::*;

  localparam int PosW = POSITION_FRACTION_BITS;
  localparam int InPosW = 17;
  localparam int CntW = $clog2(MAX_POINTS + 1);
  localparam int IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NumW = PosW + 1 + 9;
  localparam int DenW = PosW + 1;
  localparam int DivCyc = NumW;
  localparam int DcW = $clog2(DivCyc + 2);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ADD, S_DIV, S_OUT} state_t;

  state_t state_r;
  logic [23:0] start_r, end_r;
  logic [CntW-1:0] cnt_r, k_r;
  logic [DcW-1:0] dc_r;
  logic act_r;
  logic [InPosW-1:0] pos_r;
  logic [23:0] col_r, res_col_r;
  logic [1:0] res_st_r;
  logic [PosW:0] p1_r, p2_r;
  logic [23:0] c1_r, c2_r;
  logic div_go;

  logic [PosW-1:0] cpos [MAX_POINTS];
  logic [23:0] ccol [MAX_POINTS];
  logic [MAX_POINTS-1:0] sh_en, ld_en;

  // Cell at the scan index.
  logic [IdxW-1:0] kidx;
  logic [PosW:0] kpos;
  logic [23:0] kcol;
  logic kin;
  assign kidx = k_r[IdxW-1:0];
  assign kin = (k_r < cnt_r);
  assign kpos = {1'b0, cpos[kidx]};
  assign kcol = ccol[kidx];

  genvar g;
  generate
    for (g = 0; g < MAX_POINTS; g++) begin : g_cell
      logic [PosW-1:0] pp;
      logic [23:0] pc;
      if (g == 0) begin : g_first
        assign pp = '0;
        assign pc = '0;
      end else begin : g_rest
        assign pp = cpos[g-1];
        assign pc = ccol[g-1];
      end
      cgr_cell #(.PosW(PosW)) u_cell (
        .clk(clk), .shift_en(sh_en[g]), .load_en(ld_en[g]),
        .prev_pos(pp), .prev_col(pc),
        .new_pos(pos_r[PosW-1:0]), .new_col(col_r),
        .pos_r(cpos[g]), .col_r(ccol[g])
      );
    end
  endgenerate

  always_comb begin
    sh_en = '0;
    ld_en = '0;
    if (state_r == S_ADD) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
        if (CntW'(i) == k_r) ld_en[i] = 1'b1;
        else if (res_st_r == StOk && CntW'(i) > k_r && CntW'(i) <= cnt_r) sh_en[i] = 1'b1;
      end
    end
  end

  logic [PosW:0] d_v, w_v;
  logic [7:0] q [3];
  logic [NumW-1:0] num [3];
  assign d_v = pos_r[PosW:0] - p1_r;
  assign w_v = p2_r - p1_r;

  generate
    for (g = 0; g < 3; g++) begin : g_div
      logic [7:0] a, b;
      assign a = c1_r[8*g +: 8];
      assign b = c2_r[8*g +: 8];
      assign num[g] = NumW'(a) * NumW'(w_v - d_v) + NumW'(b) * NumW'(d_v);
      cgr_div #(.NumW(NumW), .DenW(DenW)) u_div (
        .clk(clk), .start(div_go), .num(num[g]), .den(w_v), .quot(q[g])
      );
    end
  endgenerate

  assign div_go = (state_r != S_DIV) || (dc_r == '0);
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {6'd0, res_st_r, res_col_r};

  logic [InPosW-1:0] one_v;
  assign one_v = InPosW'(1) << PosW;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= '0;
      end_r <= 24'hFFFFFF;
      cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'b0) start_r <= cfg_wdata;
        else end_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            act_r <= in_tdata[0];
            pos_r <= in_tdata[17:1];
            col_r <= {in_tdata[25:18], in_tdata[33:26], in_tdata[41:34]};
            k_r <= '0;
            p1_r <= '0;
            c1_r <= start_r;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          res_col_r <= '0;
          if (act_r == ActAdd) begin
            if (pos_r == '0 || pos_r >= one_v) begin
              res_st_r <= StRange;
              state_r <= S_OUT;
            end else if (kin && kpos == {1'b0, pos_r[PosW-1:0]}) begin
              res_st_r <= StUpdated;
              state_r <= S_ADD;
            end else if (!kin || kpos > {1'b0, pos_r[PosW-1:0]}) begin
              if (cnt_r >= CntW'(MAX_POINTS)) begin
                res_st_r <= StFull;
                state_r <= S_OUT;
              end else begin
                res_st_r <= StOk;
                state_r <= S_ADD;
              end
            end else begin
              k_r <= k_r + 1'b1;
            end
          end else if (pos_r > one_v) begin
            res_st_r <= StRange;
            state_r <= S_OUT;
          end else begin
            res_st_r <= StOk;
            if (pos_r == '0) begin
              res_col_r <= start_r;
              state_r <= S_OUT;
            end else if (!kin) begin
              if (pos_r == one_v) begin
                res_col_r <= end_r;
                state_r <= S_OUT;
              end else begin
                p2_r <= {1'b1, {PosW{1'b0}}};
                c2_r <= end_r;
                dc_r <= '0;
                state_r <= S_DIV;
              end
            end else if (kpos == pos_r[PosW:0]) begin
              res_col_r <= kcol;
              state_r <= S_OUT;
            end else if (kpos > pos_r[PosW:0]) begin
              p2_r <= kpos;
              c2_r <= kcol;
              dc_r <= '0;
              state_r <= S_DIV;
            end else begin
              p1_r <= kpos;
              c1_r <= kcol;
              k_r <= k_r + 1'b1;
            end
          end
        end
        S_ADD: begin
          if (res_st_r == StOk) cnt_r <= cnt_r + 1'b1;
          state_r <= S_OUT;
        end
        S_DIV: begin
          if (dc_r == DcW'(DivCyc + 1)) begin
            res_col_r <= {q[2], q[1], q[0]};
            state_r <= S_OUT;
          end else begin
            dc_r <= dc_r + 1'b1;
          end
        end
        S_OUT: begin
          if (out_tready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/cgr_cell.sv =====
// One control point cell of the ramp chain: holds a position and colour.
// Depends on cgr_pkg; instantiated by colour_gradient_ramp.
`default_nettype none
module cgr_cell #(
  parameter int PosW = 16
) (
  input  wire logic                       clk,
  input  wire logic                       shift_en,
  input  wire logic                       load_en,
  input  wire logic [PosW-1:0]            prev_pos,
  input  wire logic [cgr_pkg::ColourW-1:0] prev_col,
  input  wire logic [PosW-1:0]            new_pos,
  input  wire logic [cgr_pkg::ColourW-1:0] new_col,
  output logic      [PosW-1:0]            pos_r,
  output logic      [cgr_pkg::ColourW-1:0] col_r
);
  import cgr_pkg::*;

  always_ff @(posedge clk) begin
    if (load_en) begin
      pos_r <= new_pos;
      col_r <= new_col;
    end else if (shift_en) begin
      pos_r <= prev_pos;
      col_r <= prev_col;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/cgr_div.sv =====
// Restoring serial divider for one colour channel, one quotient bit a cycle.
// Depends on cgr_pkg; instantiated by colour_gradient_ramp.
`default_nettype none
module cgr_div #(
  parameter int NumW = 33,
  parameter int DenW = 25
) (
  input  wire logic            clk,
  input  wire logic            start,
  input  wire logic [NumW-1:0] num,
  input  wire logic [DenW-1:0] den,
  output logic      [7:0]      quot
);
  import cgr_pkg::*;

  logic [NumW-1:0] n_r;
  logic [DenW:0]   rem_r;
  logic [DenW-1:0] d_r;
  logic [NumW-1:0] q_r;
  logic [DenW:0]   trial;

  assign trial = {rem_r[DenW-1:0], n_r[NumW-1]};
  assign quot = q_r[7:0];

  always_ff @(posedge clk) begin
    if (start) begin
      n_r <= num;
      d_r <= den;
      rem_r <= '0;
      q_r <= '0;
    end else begin
      n_r <= {n_r[NumW-2:0], 1'b0};
      if (trial >= {1'b0, d_r}) begin
        rem_r <= trial - {1'b0, d_r};
        q_r <= {q_r[NumW-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r <= {q_r[NumW-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire
